// File: rtl/sorted_record_prefix_search_core_defines.svh
// Assertion macros shared by the checker of the prefix search core.
`ifndef SORTED_RECORD_PREFIX_SEARCH_CORE_DEFINES_SVH
`define SORTED_RECORD_PREFIX_SEARCH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prefix search core check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prefix search core check failed");

`endif

// File: rtl/srps_pkg.sv
package srps_pkg;

    localparam int DEF_TABLE_DEPTH      = 64;
    localparam int DEF_MAX_RECORD_BYTES = 8;
    localparam int REC_W                = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FINISH = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_RSVD   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_PHASE = 2'd2,
        STS_RSVD  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MASK_RD,
        ST_MASK_WR,
        ST_SORT_RDV,
        ST_SORT_LDV,
        ST_SORT_RDJ,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_QUERY
    } state_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

    // Mask covering bytes lo .. hi-1 of a record, counted from the least significant byte.
    function automatic logic [REC_W-1:0] byte_mask(input logic [3:0] lo, input logic [3:0] hi);
        logic [REC_W-1:0] res;
        res = '0;
        for (int i = 0; i < REC_W / 8; i++) begin
            res[8*i +: 8] = ((4'(i) >= lo) && (4'(i) < hi)) ? 8'hFF : 8'h00;
        end
        return res;
    endfunction

endpackage

// File: rtl/srps_ram.sv
module srps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/srps_cmp.sv
module srps_cmp (
    input  logic [srps_pkg::REC_W-1:0] a,
    input  logic [srps_pkg::REC_W-1:0] b,
    input  logic [srps_pkg::REC_W-1:0] mask,
    output srps_pkg::cmp_res_t         res
);
    import srps_pkg::*;

    logic [REC_W-1:0] am;
    logic [REC_W-1:0] bm;

    // Both operands are masked first, so one unit serves the sort and the prefix test.
    assign am     = a & mask;
    assign bm     = b & mask;
    assign res.gt = (am > bm);
    assign res.eq = (am == bm);

endmodule

// File: rtl/sorted_record_prefix_search_core.sv
// Sorted record table with prefix search.
// Requests enter on the command channel: a request beat is taken when start is high
// and busy is low. Insert appends a record, finish sorts the table and opens the
// query phase, and a query returns every record whose leading bytes match a prefix.
// Each result beat is shown for one cycle with result_valid high; the receiver cannot
// hold results off, so the core never waits on it. The final beat of a request has
// last high; a query without a match gives one beat with found low.
// Insert, refused requests and a finish on an empty table answer in the next cycle.
// Finish first runs a masking sweep that reads and rewrites each record, then an
// insertion sort that loads each record after the first, moves every larger neighbour
// up one place and then writes the record into the gap that is left.
// A query scans the table through the single memory read port, one record per
// cycle. A match is held back until the next match is read or the scan ends,
// so that the final beat can carry last.
// Reset empties the table, returns to the loading phase and sets record_bytes to 8.
// The record_bytes register sits at byte address 0 of the APB port; pready is
// always high and writes are only expected while busy is low.
module sorted_record_prefix_search_core #(
    parameter int TABLE_DEPTH      = srps_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_RECORD_BYTES = srps_pkg::DEF_MAX_RECORD_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 req_type,
    input  logic [srps_pkg::REC_W-1:0] record_in,
    input  logic [srps_pkg::REC_W-1:0] prefix_in,
    input  logic [3:0]                 prefix_len,
    output logic                       result_valid,
    output logic [srps_pkg::REC_W-1:0] record_out,
    output logic                       found,
    output logic                       last,
    output logic [1:0]                 status
);
    import srps_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Configuration register and its effective value.
    logic [3:0]       rb_reg;
    logic [3:0]       rb_eff;
    logic [REC_W-1:0] cur_mask;
    logic [3:0]       p_sat;

    // Sequencer state and table bookkeeping.
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             sorted_reg, sorted_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [REC_W-1:0] v_reg, v_next;
    logic [REC_W-1:0] mask_reg, mask_next;
    logic [REC_W-1:0] pm_reg, pm_next;
    logic [REC_W-1:0] key_reg, key_next;
    logic             rv_reg, rv_next;
    logic             pend_v_reg, pend_v_next;
    logic [REC_W-1:0] pend_reg, pend_next;

    // Result registers.
    logic             ov_reg, ov_next;
    logic [REC_W-1:0] orec_reg, orec_next;
    logic             ofound_reg, ofound_next;
    logic             olast_reg, olast_next;
    status_t          osts_reg, osts_next;

    // Memory and shared compare unit.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    logic [REC_W-1:0] cmp_b;
    logic [REC_W-1:0] cmp_mask;
    cmp_res_t         cmp_res;

    logic accept;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, rb_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_reg <= 4'd8;
        end
        else if (cfg_wr)
        begin
            rb_reg <= pwdata[3:0];
        end
    end

    // A zero width counts as one byte; widths above the limit saturate.
    assign rb_eff   = (rb_reg == 4'd0) ? 4'd1 :
                      (rb_reg > 4'(MAX_RECORD_BYTES)) ? 4'(MAX_RECORD_BYTES) : rb_reg;
    assign cur_mask = byte_mask(4'd0, rb_eff);
    assign p_sat    = (prefix_len > rb_eff) ? rb_eff : prefix_len;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    srps_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srps_cmp u_cmp (
        .a    (ram_rdata),
        .b    (cmp_b),
        .mask (cmp_mask),
        .res  (cmp_res)
    );

    // The sort compares against the record being inserted; the query against the key.
    assign cmp_b    = (state_reg == ST_QUERY) ? key_reg : v_reg;
    assign cmp_mask = (state_reg == ST_QUERY) ? pm_reg : mask_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !sorted_reg)
                begin
                    if ((req_type == REQ_FINISH) && (count_reg != '0))
                    begin
                        state_next = ST_MASK_RD;
                    end
                end
                else if (accept && (req_type == REQ_QUERY))
                begin
                    state_next = ST_QUERY;
                end
            end
            ST_MASK_RD:
            begin
                state_next = ST_MASK_WR;
            end
            ST_MASK_WR:
            begin
                if ((k_reg + 1'b1) != count_reg)
                begin
                    state_next = ST_MASK_RD;
                end
                else if (count_reg > CW'(1))
                begin
                    state_next = ST_SORT_RDV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SORT_RDV:
            begin
                state_next = ST_SORT_LDV;
            end
            ST_SORT_LDV:
            begin
                state_next = ST_SORT_RDJ;
            end
            ST_SORT_RDJ:
            begin
                state_next = (j_reg == '0) ? ST_SORT_PUT : ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                state_next = cmp_res.gt ? ST_SORT_RDJ : ST_SORT_PUT;
            end
            ST_SORT_PUT:
            begin
                state_next = ((k_reg + 1'b1) == count_reg) ? ST_IDLE : ST_SORT_RDV;
            end
            ST_QUERY:
            begin
                if ((k_reg == count_reg) && !rv_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and results.
    always_comb
    begin
        count_next  = count_reg;
        sorted_next = sorted_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        v_next      = v_reg;
        mask_next   = mask_reg;
        pm_next     = pm_reg;
        key_next    = key_reg;
        rv_next     = 1'b0;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        ov_next     = 1'b0;
        orec_next   = '0;
        ofound_next = 1'b0;
        olast_next  = 1'b1;
        osts_next   = STS_OK;
        ram_we      = 1'b0;
        ram_waddr   = k_reg[AW-1:0];
        ram_wdata   = record_in & cur_mask;
        ram_raddr   = k_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mask_next = cur_mask;
                    k_next    = '0;
                    if ((req_type == REQ_INSERT) && !sorted_reg)
                    begin
                        ov_next = 1'b1;
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            osts_next = STS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if ((req_type == REQ_FINISH) && !sorted_reg)
                    begin
                        sorted_next = 1'b1;
                        ov_next     = (count_reg == '0);
                    end
                    else if ((req_type == REQ_QUERY) && sorted_reg)
                    begin
                        key_next    = prefix_in;
                        pm_next     = byte_mask(rb_eff - p_sat, rb_eff);
                        pend_v_next = 1'b0;
                    end
                    else
                    begin
                        ov_next   = 1'b1;
                        osts_next = STS_PHASE;
                    end
                end
            end
            ST_MASK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & mask_reg;
                if ((k_reg + 1'b1) == count_reg)
                begin
                    k_next  = CW'(1);
                    ov_next = (count_reg == CW'(1));
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SORT_LDV:
            begin
                v_next = ram_rdata;
                j_next = k_reg;
            end
            ST_SORT_RDJ:
            begin
                ram_raddr = AW'(j_reg - 1'b1);
            end
            ST_SORT_CMP:
            begin
                // A larger neighbour moves up one place.
                if (cmp_res.gt)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - 1'b1;
                end
            end
            ST_SORT_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = v_reg;
                k_next    = k_reg + 1'b1;
                ov_next   = ((k_reg + 1'b1) == count_reg);
            end
            ST_QUERY:
            begin
                if (k_reg != count_reg)
                begin
                    k_next  = k_reg + 1'b1;
                    rv_next = 1'b1;
                end
                // The newest match is held back until it is known whether it is the final one.
                if (rv_reg && cmp_res.eq)
                begin
                    if (pend_v_reg)
                    begin
                        ov_next     = 1'b1;
                        orec_next   = pend_reg;
                        ofound_next = 1'b1;
                        olast_next  = 1'b0;
                    end
                    pend_v_next = 1'b1;
                    pend_next   = ram_rdata & mask_reg;
                end
                if ((k_reg == count_reg) && !rv_reg)
                begin
                    ov_next     = 1'b1;
                    orec_next   = pend_v_reg ? pend_reg : '0;
                    ofound_next = pend_v_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b0;
            k_reg      <= '0;
            j_reg      <= '0;
            rv_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            rv_reg     <= rv_next;
            pend_v_reg <= pend_v_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        mask_reg   <= mask_next;
        pm_reg     <= pm_next;
        key_reg    <= key_next;
        pend_reg   <= pend_next;
        orec_reg   <= orec_next;
        ofound_reg <= ofound_next;
        olast_reg  <= olast_next;
        osts_reg   <= osts_next;
    end

    assign result_valid = ov_reg;
    assign record_out   = orec_reg;
    assign found        = ofound_reg;
    assign last         = olast_reg;
    assign status       = osts_reg;

endmodule

// File: rtl/srps_checker.sv
`include "sorted_record_prefix_search_core_defines.svh"

module srps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        result_valid,
    input logic [63:0] record_out,
    input logic        found,
    input logic        last,
    input logic [1:0]  status
);
    import srps_pkg::*;

    `SRPS_ASSERT_SAME(a_nonlast_is_match, clk, rst_n, result_valid && !last, found)
    `SRPS_ASSERT_SAME(a_match_ok, clk, rst_n, result_valid && found, status == STS_OK)
    `SRPS_ASSERT_SAME(a_nomatch_zero, clk, rst_n, result_valid && !found, record_out == 64'd0)
    `SRPS_ASSERT_SAME(a_more_keeps_busy, clk, rst_n, result_valid && !last, busy)
    `SRPS_ASSERT_NEXT(a_insert_answers, clk, rst_n, start && !busy && (req_type == REQ_INSERT),
        result_valid && last)

endmodule

bind sorted_record_prefix_search_core srps_checker u_srps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .record_out   (record_out),
    .found        (found),
    .last         (last),
    .status       (status)
);
